// ===== rtl/ossp_pkg.sv =====
`default_nettype none
package ossp_pkg;

  localparam int unsigned OpWidth = 3;

  // operation codes carried by the opcode field
  typedef enum logic [OpWidth-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_EXISTS = 3'd2,
    OP_NEXT   = 3'd3,
    OP_PREV   = 3'd4
  } op_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/ossp_if.sv =====
`default_nettype none
interface ossp_in_if #(
  parameter int unsigned KEY_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [ossp_pkg::OpWidth-1:0] opcode;
  logic signed [KEY_WIDTH-1:0]  key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface ossp_out_if #(
  parameter int unsigned KEY_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic signed [KEY_WIDTH-1:0] value;
  logic                        overflow;

  modport source (output valid, output hit, output value, output overflow, input ready);
  modport sink   (input valid, input hit, input value, input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/ossp_cell.sv =====
`default_nettype none
module ossp_cell #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ossp_pkg::cell_cmd_t   cmd,
  input  wire logic [KEY_WIDTH-1:0]  query,
  // left neighbor (smaller slot)
  input  wire logic [KEY_WIDTH-1:0]  left_key,
  input  wire logic                  left_valid,
  input  wire logic                  left_bigger,
  input  wire logic                  left_gtv,
  // right neighbor (larger slot)
  input  wire logic [KEY_WIDTH-1:0]  right_key,
  input  wire logic                  right_valid,
  input  wire logic                  right_ltv,
  // own state toward the neighbors
  output logic [KEY_WIDTH-1:0]       key,
  output logic                       valid,
  output logic                       bigger,
  output logic                       gtv,
  output logic                       ltv,
  output logic                       eq,
  // masked neighbor values for the result tree
  output logic [KEY_WIDTH-1:0]       next_val,
  output logic [KEY_WIDTH-1:0]       prev_val
);
  import ossp_pkg::*;

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 valid_r, valid_nxt;
  logic                 next_sel;
  logic                 prev_sel;
  logic                 ge;

  // signed compare against the query
  always_comb begin
    gtv      = valid_r && ($signed(key_r) > $signed(query));
    ltv      = valid_r && ($signed(key_r) < $signed(query));
    eq       = valid_r && (key_r == query);
    ge       = gtv || eq;
    bigger   = !valid_r || gtv;
    next_sel = gtv && !left_gtv;
    prev_sel = ltv && !right_ltv;
    next_val = next_sel ? key_r : '0;
    prev_val = prev_sel ? key_r : '0;
    key      = key_r;
    valid    = valid_r;
  end

  // shift right on insert, shift left on delete
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.ins_en && bigger) begin
      key_nxt   = left_bigger ? left_key : query;
      valid_nxt = valid_r || left_valid;
    end else if (cmd.del_en && ge) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ordered_set_successor_predecessor.sv =====
`default_nettype none
// Ordered set of up to CAPACITY distinct signed keys held in a row of cells,
// sorted ascending and packed from slot 0. Each input transaction (insert,
// delete, exists, next greater, previous smaller) yields exactly one result
// transaction. The item is first registered; then, in the execute state, every
// cell compares its key with the query in parallel and, on insert or delete,
// takes its neighbor's key (or, on insert, the query); the result goes to an
// output register. Execute waits while that register holds an untaken result.
// A new item is taken only once the previous one has reached that register.
// An insert into a full store is dropped and reported with overflow.
module ordered_set_successor_predecessor #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ossp_in_if.sink   in_ch,
  ossp_out_if.source out_ch
);
  import ossp_pkg::*;

  state_t               state_r, state_nxt;
  logic [OpWidth-1:0]   op_r;
  logic [KEY_WIDTH-1:0] query_r;
  cell_cmd_t            cmd;
  logic                 exec_go;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [KEY_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic [KEY_WIDTH-1:0] c_key      [CAPACITY];
  logic                 c_valid    [CAPACITY];
  logic                 c_bigger   [CAPACITY];
  logic                 c_gtv      [CAPACITY];
  logic                 c_ltv      [CAPACITY];
  logic                 c_eq       [CAPACITY];
  logic [KEY_WIDTH-1:0] c_next_val [CAPACITY];
  logic [KEY_WIDTH-1:0] c_prev_val [CAPACITY];

  logic                 present;
  logic                 any_gtv;
  logic                 full;
  logic [KEY_WIDTH-1:0] next_key;
  logic [KEY_WIDTH-1:0] prev_key;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] l_key, r_key;
    logic                 l_valid, l_bigger, l_gtv, r_valid, r_ltv;
    if (i == 0) begin : g_first
      assign l_key    = '0;
      assign l_valid  = 1'b1;
      assign l_bigger = 1'b0;
      assign l_gtv    = 1'b0;
    end else begin : g_mid_l
      assign l_key    = c_key[i-1];
      assign l_valid  = c_valid[i-1];
      assign l_bigger = c_bigger[i-1];
      assign l_gtv    = c_gtv[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_key   = '0;
      assign r_valid = 1'b0;
      assign r_ltv   = 1'b0;
    end else begin : g_mid_r
      assign r_key   = c_key[i+1];
      assign r_valid = c_valid[i+1];
      assign r_ltv   = c_ltv[i+1];
    end

    ossp_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .query       (query_r),
      .left_key    (l_key),
      .left_valid  (l_valid),
      .left_bigger (l_bigger),
      .left_gtv    (l_gtv),
      .right_key   (r_key),
      .right_valid (r_valid),
      .right_ltv   (r_ltv),
      .key         (c_key[i]),
      .valid       (c_valid[i]),
      .bigger      (c_bigger[i]),
      .gtv         (c_gtv[i]),
      .ltv         (c_ltv[i]),
      .eq          (c_eq[i]),
      .next_val    (c_next_val[i]),
      .prev_val    (c_prev_val[i])
    );
  end

  // combine per-cell flags and one-hot selected neighbors
  always_comb begin
    present  = 1'b0;
    any_gtv  = 1'b0;
    next_key = '0;
    prev_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      present  = present | c_eq[i];
      any_gtv  = any_gtv | c_gtv[i];
      next_key = next_key | c_next_val[i];
      prev_key = prev_key | c_prev_val[i];
    end
    full = c_valid[CAPACITY-1];
  end

  // sequencer and result formation
  always_comb begin
    state_nxt     = state_r;
    exec_go       = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    in_ch.ready   = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        exec_go = !out_valid_r || out_ch.ready;
        if (exec_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_value_nxt = '0;
          out_ovf_nxt   = 1'b0;
          unique case (op_r)
            OP_INSERT: begin
              cmd.ins_en  = !present && !full;
              out_hit_nxt = !present && !full;
              out_ovf_nxt = !present && full;
            end
            OP_DELETE: begin
              cmd.del_en  = present;
              out_hit_nxt = present;
            end
            OP_EXISTS: begin
              out_hit_nxt = present;
            end
            OP_NEXT: begin
              out_hit_nxt   = any_gtv;
              out_value_nxt = next_key;
            end
            OP_PREV: begin
              out_hit_nxt   = c_ltv[0];
              out_value_nxt = prev_key;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r    <= in_ch.opcode;
      query_r <= in_ch.key;
    end
    out_hit_r   <= out_hit_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit      = out_hit_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.overflow = out_ovf_r;

endmodule
`default_nettype wire

// ===== rtl/ossp_checker.sv =====
`default_nettype none
module ossp_checker #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_hit,
  input wire logic [KEY_WIDTH-1:0] out_value,
  input wire logic                 out_overflow
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a dropped insert never reports a hit, a value is only given with a hit
  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overflow && out_hit) && (out_hit || out_value == '0))
    else $error("inconsistent result fields");

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_hit) && $stable(out_value) && $stable(out_overflow))
    else $error("result changed while stalled");

endmodule

bind ordered_set_successor_predecessor ossp_checker #(.KEY_WIDTH(KEY_WIDTH)) u_ossp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_hit      (out_ch.hit),
  .out_value    (out_ch.value),
  .out_overflow (out_ch.overflow)
);
`default_nettype wire

// ===== bench/ossp_tb_pkg.sv =====
`timescale 1ns / 1ps
package ossp_tb_pkg;
  import ossp_pkg::*;

  localparam int unsigned SetCapacity = 64;
  localparam int unsigned KeyWidth    = 32;

  // opcodes past the last defined operation act as no-ops
  localparam logic [OpWidth-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OpWidth-1:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [OpWidth-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef logic signed [KeyWidth-1:0] key_t;

  typedef struct {
    logic hit;
    key_t value;
    logic overflow;
  } set_result_t;

  // mirrors the sorted key store and queues the answer owed for each request
  class ossp_scoreboard;
    key_t        stored_keys[$];
    set_result_t awaited_results[$];
    int          errors;
    int          checked;
    int          dropped_inserts;
    int          peak_fill;
    int          op_seen[8];

    function new();
      errors          = 0;
      checked         = 0;
      dropped_inserts = 0;
      peak_fill       = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // apply one accepted request to the mirrored set
    function void note_request(logic [OpWidth-1:0] op, key_t key);
      set_result_t res;
      int          lo;
      int          hi;
      bit          present;
      res = '{hit: 1'b0, value: '0, overflow: 1'b0};
      lo  = 0;
      while (lo < stored_keys.size() && stored_keys[lo] < key) lo++;
      present = (lo < stored_keys.size()) && (stored_keys[lo] == key);
      op_seen[op]++;
      case (op)
        OP_INSERT: begin
          if (!present) begin
            if (stored_keys.size() >= SetCapacity) begin
              res.overflow = 1'b1;
              dropped_inserts++;
            end else begin
              stored_keys.insert(lo, key);
              res.hit = 1'b1;
            end
          end
        end
        OP_DELETE: begin
          if (present) begin
            stored_keys.delete(lo);
            res.hit = 1'b1;
          end
        end
        OP_EXISTS: res.hit = present;
        OP_NEXT: begin
          hi = lo;
          while (hi < stored_keys.size() && stored_keys[hi] <= key) hi++;
          if (hi < stored_keys.size()) begin
            res.hit   = 1'b1;
            res.value = stored_keys[hi];
          end
        end
        OP_PREV: begin
          if (lo > 0) begin
            res.hit   = 1'b1;
            res.value = stored_keys[lo-1];
          end
        end
        default: ;
      endcase
      if (stored_keys.size() > peak_fill) peak_fill = stored_keys.size();
      awaited_results.push_back(res);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // compare one result transaction with the oldest owed answer
    task check_response(logic hit, key_t value, logic overflow);
      set_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with none pending (hit %0b value %0d)", hit, value));
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (hit !== want.hit)
        report($sformatf("hit %0b, wanted %0b", hit, want.hit));
      if (value !== want.value)
        report($sformatf("value %0d, wanted %0d", value, want.value));
      if (overflow !== want.overflow)
        report($sformatf("overflow %0b, wanted %0b", overflow, want.overflow));
    endtask
  endclass

endpackage

// ===== bench/tb_ordered_set_successor_predecessor.sv =====
`timescale 1ns / 1ps
module tb_ordered_set_successor_predecessor;
  import ossp_pkg::*;
  import ossp_tb_pkg::*;

  localparam int RandomItems  = 1525;
  localparam int CalmTail     = 200;
  localparam int LongHold     = 300;
  localparam int HoldAtItem   = 500;
  localparam int PauseAtItem  = 900;
  localparam int PhaseLen     = 60;
  localparam int DrainCycles  = 20;
  localparam int WatchdogMax  = 4000;
  localparam key_t KEY_MIN    = 32'sh8000_0000;
  localparam key_t KEY_MAX    = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_request = 1'b0;
  bit   calm = 1'b0;
  int   sent = 0;
  key_t key_pool[48];

  ossp_scoreboard sb = new();

  ossp_in_if  #(.KEY_WIDTH(KeyWidth)) in_ch ();
  ossp_out_if #(.KEY_WIDTH(KeyWidth)) out_ch ();

  ordered_set_successor_predecessor #(
    .CAPACITY (SetCapacity),
    .KEY_WIDTH(KeyWidth)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // clock
  always #2 clk = ~clk;

  // offer one transaction and hold it until accepted
  task send_item(logic [OpWidth-1:0] op, key_t key);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key    <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(op, key);
    sent++;
  endtask

  // random gap on the input side
  task maybe_idle();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // operation mix depends on whether the phase fills, drains or mixes
  function automatic logic [OpWidth-1:0] pick_op(int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OpWidth'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    case (phase)
      0, 1: begin
        if (r < 65) return OP_INSERT;
        if (r < 75) return OP_DELETE;
      end
      3: begin
        if (r < 18) return OP_INSERT;
        if (r < 70) return OP_DELETE;
      end
      default: begin
        if (r < 30) return OP_INSERT;
        if (r < 50) return OP_DELETE;
      end
    endcase
    case ($urandom_range(0, 2))
      0:       return OP_EXISTS;
      1:       return OP_NEXT;
      default: return OP_PREV;
    endcase
  endfunction

  // keys near stored ones, from a shared pool, extremes or fully random
  function automatic key_t pick_key();
    int   r;
    int   n;
    key_t k;
    r = $urandom_range(0, 99);
    n = sb.stored_keys.size();
    if (r < 40 && n > 0) begin
      k = sb.stored_keys[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 3))
        1: k = k + 1;
        2: k = k - 1;
        default: ;
      endcase
    end else if (r < 70) begin
      k = key_pool[$urandom_range(0, 47)];
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = -1;
        default: k = 0;
      endcase
    end else begin
      k = key_t'($urandom);
    end
    return k;
  endfunction

  // reset and stimulus
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_INSERT;
    in_ch.key    <= '0;
    foreach (key_pool[i])
      key_pool[i] = (i % 2) ? key_t'($urandom) : key_t'(int'($urandom_range(0, 40)) - 20);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extremes, duplicates, missing neighbors, no-ops
    send_item(OP_PREV,   KEY_MIN);
    send_item(OP_NEXT,   KEY_MAX);
    send_item(OP_EXISTS, 0);
    send_item(OP_DELETE, 0);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, KEY_MAX);
    send_item(OP_INSERT, KEY_MIN);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, 1);
    send_item(OP_EXISTS, -1);
    send_item(OP_EXISTS, 5);
    send_item(OP_NEXT,   KEY_MAX);
    send_item(OP_NEXT,   KEY_MIN);
    send_item(OP_NEXT,   -2);
    send_item(OP_PREV,   KEY_MIN);
    send_item(OP_PREV,   KEY_MAX);
    send_item(OP_PREV,   0);
    send_item(OP_DELETE, KEY_MAX);
    send_item(OP_DELETE, KEY_MAX);
    send_item(OP_NEXT,   1);
    send_item(OP_UNUSED_FIRST, KEY_MAX);
    send_item(OP_UNUSED_MID, -1);
    send_item(OP_UNUSED_LAST, KEY_MIN);

    // random phases of filling, mixing and draining
    for (int i = 0; i < RandomItems; i++) begin
      logic [OpWidth-1:0] op;
      calm = (i >= RandomItems - CalmTail);
      if (i == HoldAtItem) hold_request = 1'b1;
      if (i == PauseAtItem) begin
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      maybe_idle();
      op = pick_op((i / PhaseLen) % 4);
      send_item(op, pick_key());
    end
    in_ch.valid <= 1'b0;

    // let the block drain, then conclude
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d requests: insert %0d, delete %0d, exists %0d, next %0d, prev %0d",
             sent, sb.op_seen[OP_INSERT], sb.op_seen[OP_DELETE], sb.op_seen[OP_EXISTS],
             sb.op_seen[OP_NEXT], sb.op_seen[OP_PREV]);
    $display("Checked %0d results; peak fill %0d of %0d, %0d inserts dropped when full",
             sb.checked, sb.peak_fill, SetCapacity, sb.dropped_inserts);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: check each transaction, stall at random or on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_response(out_ch.hit, out_ch.value, out_ch.overflow);
      if (hold_request) begin
        stall_left   = LongHold;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left   = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchdogMax) begin
        $display("timeout after %0d quiet cycles, %0d results pending", quiet, sb.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
